FILE: src/atsc_pkg.sv
package atsc_pkg;

  // The pipeline has one discriminant stage, the root stages, two scaling stages and the
  // output stage.
  localparam int ROOT_BITS        = 46;
  localparam int ROOT_STEPS_STAGE = 2;
  localparam int ROOT_STAGES      = ROOT_BITS / ROOT_STEPS_STAGE;
  localparam int NUM_STAGES       = ROOT_STAGES + 4;
  localparam int CNT_W            = $clog2(NUM_STAGES + 1);

  localparam int RAD_W  = 28;
  localparam int REM_W  = 48;
  localparam int TEMP_W = 19;

  // The discriminant is scaled by one million.
  localparam logic [RAD_W-1:0] DISC_OFFSET = 28'd223108180;
  localparam logic [14:0]      DISC_SLOPE  = 15'd17320;

  // The root is split at the binary point and each half is scaled by 10000.
  // Adding the floor bias gives a value that is never negative; its quotient by 866
  // exceeds the true quotient by 153839.
  localparam logic [13:0]       TEMP_SCALE  = 14'd10000;
  localparam logic [27:0]       FLOOR_BIAS  = 28'd3007;
  localparam logic [28:0]       RECIP_866   = 29'd317410978;
  localparam int                RECIP_SHIFT = 38;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 19'd153839;

  // The result the vertex of the curve gives when the discriminant is clamped.
  localparam logic signed [TEMP_W-1:0] TEMP_VERTEX = -19'sd153836;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 19'sd18645;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [ROOT_BITS-1:0] root;
    logic [RAD_W-1:0]     rad;
  } root_st_t;

  function automatic root_st_t root_step(root_st_t s);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    root_st_t         r;
    acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = REM_W'(acc - trial);
      r.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = acc[REM_W-1:0];
      r.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: src/atsc_if.sv
interface atsc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sensor_millivolts;

  modport source (output valid, output sensor_millivolts, input ready);
  modport sink (input valid, input sensor_millivolts, output ready);
endinterface

interface atsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] temp_centidegrees;
  logic               disc_clamped;

  modport source (output valid, output temp_centidegrees, output disc_clamped, input ready);
  modport sink (input valid, input temp_centidegrees, input disc_clamped, output ready);
endinterface

FILE: src/analog_temp_sensor_to_celsius_top.sv
// Each beat passes the discriminant, root, scaling and output registers in order.
// Throughput: one beat per cycle unless stalled; the depth is set by 23 two-step root stages.
// A stall holds each full stage; empty stages still fill, so input is taken while a result waits.
// Reset is asynchronous and active low; it clears the valid bit of every stage.
// The data registers are not reset.
module analog_temp_sensor_to_celsius_top
  import atsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  atsc_in_if.sink  in_i,
  atsc_out_if.source out_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES:0]   adv;
  logic                  clamp_q [NUM_STAGES];

  logic [31:0]       dprod;
  logic              clamp_d;
  logic [RAD_W-1:0]  rad_d;
  logic [RAD_W-1:0]  rad_q;

  root_st_t root_q [ROOT_STAGES];

  logic [27:0]           hi_prod;
  logic [45:0]           lo_prod;
  logic [27:0]           scaled_d, scaled_q;
  logic [56:0]           quot_prod;
  logic [17:0]           quot_d, quot_q;
  logic [TEMP_W-1:0]     temp_d, temp_q;

  always_comb begin
    adv[NUM_STAGES] = out_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (!adv[k]) begin
        valid_d[k] = valid_q[k];
      end else if (k == 0) begin
        valid_d[k] = in_i.valid;
      end else begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    dprod = 32'(in_i.sensor_millivolts) * 32'(DISC_SLOPE);
    if (dprod > 32'(DISC_OFFSET)) begin
      clamp_d = 1'b1;
      rad_d   = '0;
    end else begin
      clamp_d = 1'b0;
      rad_d   = RAD_W'(32'(DISC_OFFSET) - dprod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rad_q      <= rad_d;
      clamp_q[0] <= clamp_d;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        clamp_q[k] <= clamp_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
    root_st_t st_in;
    root_st_t st_out;

    if (g == 0) begin : g_first
      assign st_in = '{rem: '0, root: '0, rad: rad_q};
    end else begin : g_next
      assign st_in = root_q[g-1];
    end

    always_comb begin
      st_out = st_in;
      for (int s = 0; s < ROOT_STEPS_STAGE; s++) begin
        st_out = root_step(st_out);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[g+1]) begin
        root_q[g] <= st_out;
      end
    end
  end

  always_comb begin
    hi_prod  = 28'(root_q[ROOT_STAGES-1].root[ROOT_BITS-1:32]) * 28'(TEMP_SCALE);
    lo_prod  = 46'(root_q[ROOT_STAGES-1].root[31:0]) * 46'(TEMP_SCALE);
    scaled_d = hi_prod + 28'(lo_prod[45:32]);
  end

  always_comb begin
    quot_prod = 57'(scaled_q + FLOOR_BIAS) * 57'(RECIP_866);
    quot_d    = quot_prod[RECIP_SHIFT +: 18];
    temp_d    = {1'b0, quot_q} - TEMP_OFFSET;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ROOT_STAGES+1]) begin
      scaled_q <= scaled_d;
    end
    if (adv[ROOT_STAGES+2]) begin
      quot_q <= quot_d;
    end
    if (adv[ROOT_STAGES+3]) begin
      temp_q <= temp_d;
    end
  end

  assign in_i.ready              = adv[0];
  assign out_o.valid             = valid_q[NUM_STAGES-1];
  assign out_o.temp_centidegrees = temp_q;
  assign out_o.disc_clamped      = clamp_q[NUM_STAGES-1];

endmodule

FILE: src/atsc_checker.sv
module atsc_checker
  import atsc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [TEMP_W-1:0] temp_centidegrees_i,
  input logic                     disc_clamped_i
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(temp_centidegrees_i) && $stable(disc_clamped_i))
    else $error("Stalled result beat changed or was dropped.");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("Result beat without an accepted input beat.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_STAGES))
    else $error("More beats in flight than pipeline stages.");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("Empty pipeline refused an input beat.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (temp_centidegrees_i <= TEMP_MAX) &&
      (temp_centidegrees_i >= TEMP_VERTEX) &&
      (!disc_clamped_i || temp_centidegrees_i == TEMP_VERTEX))
    else $error("Temperature out of range or clamped result not at the vertex.");

endmodule

bind analog_temp_sensor_to_celsius_top atsc_checker u_atsc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .temp_centidegrees_i (out_o.temp_centidegrees),
  .disc_clamped_i      (out_o.disc_clamped)
);
